// File: rtl/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH_BACK  = 2'd0,
    ACT_PUSH_FRONT = 2'd1,
    ACT_POP_BACK   = 2'd2,
    ACT_POP_FRONT  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_POP_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_BACK,
    CELL_TAP_SHIFT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

endpackage

// File: rtl/deq_if.sv
// Request and response channel interfaces of the double-ended queue.
interface deq_req_if #(
  parameter int DATA_WIDTH = 32
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [DATA_WIDTH-1:0] push_value;

  modport source (output valid, action, push_value, input ready);
  modport sink   (input valid, action, push_value, output ready);
endinterface

interface deq_rsp_if #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_WIDTH  = 5
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] pop_value;
  logic [1:0]            status;
  logic [CNT_WIDTH-1:0]  entry_count;
  logic                  is_empty;

  modport source (output valid, pop_value, status, entry_count, is_empty, input ready);
  modport sink   (input valid, pop_value, status, entry_count, is_empty, output ready);
endinterface

// File: rtl/double_ended_queue_top.sv
// Top level of the double-ended queue: control, cell chain and response register.
//
//   channel | modport | direction | payload
//   req_i   | sink    | in        | action, push_value
//   rsp_o   | source  | out       | pop_value, status, entry_count, is_empty
//
// Pushes, pop front and every refused operation answer in the cycle after the
// request is taken. On pop back the back cell loads its word into its tap;
// the word walks the tap chain one cell per cycle towards cell 0, then loads
// the response register once it is free. Reset clears the occupancy bits, the
// count, the drain state and the response valid; no clearing pass. A new item
// is taken while no pop back walks the chain and the response register is free
// or being emptied; a stalled response holds both sides.
module double_ended_queue_top #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  deq_req_if.sink    req_i,
  deq_rsp_if.source  rsp_o
);

  localparam int CNT_WIDTH = $clog2(DEPTH + 1);
  localparam int IDX_WIDTH = $clog2(DEPTH);
  localparam logic [CNT_WIDTH-1:0] DepthCnt = CNT_WIDTH'(DEPTH);

  deq_pkg::state_e       state_q, state_d;
  deq_pkg::cell_ctrl_t   cell_ctrl;
  deq_pkg::action_e      action;

  logic [CNT_WIDTH-1:0]  count_q, count_d, count_m1, count_p1;
  logic [IDX_WIDTH-1:0]  drain_q, drain_d;

  logic                  rsp_valid_q, rsp_valid_d;
  logic [DATA_WIDTH-1:0] rsp_value_q, rsp_value_d;
  deq_pkg::status_e      rsp_status_q, rsp_status_d;
  logic [CNT_WIDTH-1:0]  rsp_count_q, rsp_count_d;

  logic                  slot_free, accept, is_full, is_empty;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DEPTH-1:0]      cell_valid;

  assign action    = deq_pkg::action_e'(req_i.action);
  assign slot_free = !rsp_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == deq_pkg::ST_IDLE) && slot_free;
  assign accept    = req_i.valid && req_i.ready;
  assign is_full   = (count_q == DepthCnt);
  assign is_empty  = (count_q == '0);
  assign count_m1  = count_q - CNT_WIDTH'(1);
  assign count_p1  = count_q + CNT_WIDTH'(1);

  // cell chain
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data, right_data, right_tap;
    logic                  left_valid, right_valid;

    if (k == 0) begin : g_first
      assign left_data  = req_i.push_value;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[k-1];
      assign left_valid = cell_valid[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
      assign right_tap   = '0;
    end else begin : g_inner_right
      assign right_data  = cell_data[k+1];
      assign right_valid = cell_valid[k+1];
      assign right_tap   = cell_tap[k+1];
    end

    deq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (cell_ctrl),
      .push_data_i  (req_i.push_value),
      .left_data_i  (left_data),
      .left_valid_i (left_valid),
      .right_data_i (right_data),
      .right_valid_i(right_valid),
      .right_tap_i  (right_tap),
      .data_o       (cell_data[k]),
      .valid_o      (cell_valid[k]),
      .tap_o        (cell_tap[k])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        if (accept && (action == deq_pkg::ACT_POP_BACK) && !is_empty) begin
          state_d = deq_pkg::ST_DRAIN;
        end
      end
      deq_pkg::ST_DRAIN: begin
        if ((drain_q == '0) && slot_free) begin
          state_d = deq_pkg::ST_IDLE;
        end
      end
      default: state_d = deq_pkg::ST_IDLE;
    endcase
  end

  // datapath control and response
  always_comb begin
    cell_ctrl.op = deq_pkg::CELL_HOLD;
    count_d      = count_q;
    drain_d      = drain_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_value_d  = rsp_value_q;
    rsp_status_d = rsp_status_q;
    rsp_count_d  = rsp_count_q;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        if (accept) begin
          rsp_valid_d  = 1'b1;
          rsp_value_d  = '0;
          rsp_status_d = deq_pkg::STS_OK;
          rsp_count_d  = count_q;
          unique case (action) inside
            deq_pkg::ACT_PUSH_BACK, deq_pkg::ACT_PUSH_FRONT: begin
              if (is_full) begin
                rsp_status_d = deq_pkg::STS_FULL;
              end else begin
                cell_ctrl.op = (action == deq_pkg::ACT_PUSH_BACK) ?
                               deq_pkg::CELL_PUSH_BACK : deq_pkg::CELL_PUSH_FRONT;
                count_d      = count_p1;
                rsp_count_d  = count_p1;
              end
            end
            deq_pkg::ACT_POP_FRONT: begin
              if (is_empty) begin
                rsp_status_d = deq_pkg::STS_EMPTY;
              end else begin
                cell_ctrl.op = deq_pkg::CELL_POP_FRONT;
                count_d      = count_m1;
                rsp_value_d  = cell_data[0];
                rsp_count_d  = count_m1;
              end
            end
            deq_pkg::ACT_POP_BACK: begin
              if (is_empty) begin
                rsp_status_d = deq_pkg::STS_EMPTY;
              end else begin
                // response waits until the back word reaches cell 0
                cell_ctrl.op = deq_pkg::CELL_POP_BACK;
                count_d      = count_m1;
                drain_d      = count_m1[IDX_WIDTH-1:0];
                rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
                rsp_value_d  = rsp_value_q;
                rsp_status_d = rsp_status_q;
                rsp_count_d  = rsp_count_q;
              end
            end
            default: begin
            end
          endcase
        end
      end
      deq_pkg::ST_DRAIN: begin
        if (drain_q != '0) begin
          cell_ctrl.op = deq_pkg::CELL_TAP_SHIFT;
          drain_d      = drain_q - IDX_WIDTH'(1);
        end else if (slot_free) begin
          rsp_valid_d  = 1'b1;
          rsp_value_d  = cell_tap[0];
          rsp_status_d = deq_pkg::STS_OK;
          rsp_count_d  = count_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      count_q     <= '0;
      drain_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drain_q     <= drain_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_value_q  <= rsp_value_d;
    rsp_status_q <= rsp_status_d;
    rsp_count_q  <= rsp_count_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.pop_value   = rsp_value_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.is_empty    = (rsp_count_q == '0);

`ifndef ASSERT_OFF
  // occupancy bits always agree with the count
  a_count_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == count_q)
    else $error("occupied cells do not match the count");

  // occupied cells form one run starting at cell 0
  a_valid_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("occupied cells are not packed towards the front");

  // no item is taken while a pop back walks the chain
  a_drain_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == deq_pkg::ST_DRAIN) |-> !req_i.ready)
    else $error("request taken during pop back");

  // a pop back taken on a non-empty deque moves the control into the drain state
  a_pop_back_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action == deq_pkg::ACT_POP_BACK) && !is_empty) |=>
    (state_q == deq_pkg::ST_DRAIN))
    else $error("pop back did not enter the drain");
`endif

endmodule

// File: rtl/deq_cell.sv
// One storage cell of the deque chain: a word, its occupancy bit and a read tap.
module deq_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  deq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  input  logic [DATA_WIDTH-1:0] left_data_i,
  input  logic                  left_valid_i,
  input  logic [DATA_WIDTH-1:0] right_data_i,
  input  logic                  right_valid_i,
  input  logic [DATA_WIDTH-1:0] right_tap_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [DATA_WIDTH-1:0] tap_q, tap_d;
  logic                  valid_q, valid_d;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    tap_d   = tap_q;
    unique case (ctrl_i.op)
      deq_pkg::CELL_HOLD: begin
      end
      deq_pkg::CELL_PUSH_FRONT: begin
        data_d  = left_data_i;
        valid_d = left_valid_i;
      end
      deq_pkg::CELL_POP_FRONT: begin
        data_d  = right_data_i;
        valid_d = right_valid_i;
      end
      deq_pkg::CELL_PUSH_BACK: begin
        // first free cell takes the word
        if (!valid_q && left_valid_i) begin
          data_d  = push_data_i;
          valid_d = 1'b1;
        end
      end
      deq_pkg::CELL_POP_BACK: begin
        // the back cell loads its word into the tap and frees itself
        tap_d   = (valid_q && !right_valid_i) ? data_q : '0;
        valid_d = valid_q && right_valid_i;
      end
      deq_pkg::CELL_TAP_SHIFT: begin
        tap_d = right_tap_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    tap_q  <= tap_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign tap_o   = tap_q;

endmodule
